### hw/rtl/tone_and_spike_pressure_generator_macros.svh
// Assertion shorthands for the checker file of this block.
// Both forms sample on the rising edge of clk and are switched off while rst is high.
`ifndef TONE_AND_SPIKE_PRESSURE_GENERATOR_MACROS_SVH
`define TONE_AND_SPIKE_PRESSURE_GENERATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tone and spike generator: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TSP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tone and spike generator: next-cycle check failed");

`endif

### hw/rtl/tsp_pkg.sv
`default_nettype none

package tsp_pkg;

  // Fixed field widths.
  localparam int NOW_W       = 48;
  localparam int PHASE_W     = 48;
  localparam int STEP_W      = 40;
  localparam int PRESSURE_W  = 32;
  localparam int TURNS_W     = 16;
  localparam int CFG_DATA_W  = 40;
  localparam int CFG_INDEX_W = 3;

  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ENABLE          = 3'd0,
    REG_BASE_PRESSURE   = 3'd1,
    REG_TONE_STEP       = 3'd2,
    REG_TONE_AMPLITUDE  = 3'd3,
    REG_SPIKE_AMPLITUDE = 3'd4,
    REG_SPIKE_PERIOD    = 3'd5
  } tsp_reg_t;

  // Operand pairs for the shared multiplier.
  typedef enum logic [1:0] {
    MUL_LO_LO,
    MUL_LO_HI,
    MUL_HI_LO,
    MUL_TONE
  } tsp_mul_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_PHASE,
    ST_ROM,
    ST_TONE,
    ST_ARM,
    ST_CHECK,
    ST_DIV,
    ST_ALIGN,
    ST_ADVANCE,
    ST_FINISH
  } tsp_state_t;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    tsp_mul_t mul_sel;
    logic     acc_load;
    logic     acc_add;
    logic     rom_en;
    logic     arm_en;
    logic     check_en;
    logic     div_start;
    logic     align_en;
    logic     adv_en;
    logic     finish;
  } tsp_cmd_t;

  typedef struct packed {
    logic enable;
    logic hit;
    logic rem_short;
    logic div_done;
  } tsp_status_t;

  // Sine of a quarter-wave turn fraction f (Q30 of a quarter turn), Q30 result in
  // [0, 1.0]. Only evaluated at elaboration to fill the constant table.
  function automatic logic [30:0] sine_q30(input logic [63:0] f);
    logic [63:0]        theta;
    logic [63:0]        th2;
    logic [63:0]        term;
    logic signed [65:0] sum;
    theta = (f * HALF_PI_Q30) >> 30;
    th2   = (theta * theta) >> 30;
    term  = theta;
    sum   = $signed({2'b00, theta});
    term  = ((term * th2) >> 30) / 64'd6;
    sum   = sum - $signed({2'b00, term});
    term  = ((term * th2) >> 30) / 64'd20;
    sum   = sum + $signed({2'b00, term});
    term  = ((term * th2) >> 30) / 64'd42;
    sum   = sum - $signed({2'b00, term});
    term  = ((term * th2) >> 30) / 64'd72;
    sum   = sum + $signed({2'b00, term});
    term  = ((term * th2) >> 30) / 64'd110;
    sum   = sum - $signed({2'b00, term});
    term  = ((term * th2) >> 30) / 64'd156;
    sum   = sum + $signed({2'b00, term});
    if (sum < 0) begin
      sum = '0;
    end
    if (sum > $signed({2'b00, Q30_ONE})) begin
      sum = $signed({2'b00, Q30_ONE});
    end
    return sum[30:0];
  endfunction

endpackage

`default_nettype wire

### hw/rtl/tsp_rem.sv
`default_nettype none

// Restoring remainder unit, one dividend bit per cycle.
module tsp_rem #(
  parameter int TIME_WIDTH = 48
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [TIME_WIDTH-1:0] dividend,
  input  wire logic [31:0]           divisor,
  output logic                       done,
  output logic [31:0]                rem
);

  localparam int CW = $clog2(TIME_WIDTH + 1);

  logic                  busy;
  logic [CW-1:0]         cnt;
  logic [TIME_WIDTH-1:0] shreg;
  logic [32:0]           shifted;
  logic [33:0]           trial;

  assign shifted = {rem, shreg[TIME_WIDTH-1]};
  assign trial   = {1'b0, shifted} - {2'b00, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(TIME_WIDTH);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      rem   <= '0;
    end else if (busy) begin
      shreg <= {shreg[TIME_WIDTH-2:0], 1'b0};
      if (!trial[33]) begin
        rem <= trial[31:0];
      end else begin
        rem <= shifted[31:0];
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/tsp_ctrl.sv
`default_nettype none

// Sequencer for one tick: phase multiply, sine lookup, tone scale, spike
// deadline update and the final sum, then hands the result to the output stage.
module tsp_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  input  wire tsp_pkg::tsp_status_t status,
  output tsp_pkg::tsp_cmd_t         cmd
);

  import tsp_pkg::*;

  tsp_state_t state;
  tsp_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (status.enable) begin
            state_next = ST_MUL0;
          end
        end
      end
      ST_MUL0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_LO_LO;
        state_next  = ST_MUL1;
      end
      ST_MUL1: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MUL_LO_HI;
        cmd.acc_load = 1'b1;
        state_next   = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_HI_LO;
        cmd.acc_add = 1'b1;
        state_next  = ST_PHASE;
      end
      ST_PHASE: begin
        cmd.acc_add = 1'b1;
        state_next  = ST_ROM;
      end
      ST_ROM: begin
        cmd.rom_en = 1'b1;
        state_next = ST_TONE;
      end
      ST_TONE: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_TONE;
        state_next  = ST_ARM;
      end
      ST_ARM: begin
        cmd.arm_en = 1'b1;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.check_en = 1'b1;
        if (status.hit && !status.rem_short) begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIV;
        end else if (status.hit) begin
          state_next = ST_ALIGN;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_DIV: begin
        if (status.div_done) begin
          state_next = ST_ALIGN;
        end
      end
      ST_ALIGN: begin
        cmd.align_en = 1'b1;
        state_next   = ST_ADVANCE;
      end
      ST_ADVANCE: begin
        cmd.adv_en = 1'b1;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid || !out_stall) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/tsp_datapath.sv
`default_nettype none

// Configuration registers, shared multiplier, quarter-wave sine table, spike
// deadline and publish timers, and the output word registers.
module tsp_datapath #(
  parameter int SINE_TABLE_DEPTH    = 1024,
  parameter int PUBLISH_INTERVAL_US = 100000,
  parameter int TIME_WIDTH          = 48
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_write,
  input  wire logic [tsp_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  wire logic [tsp_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  wire logic [tsp_pkg::NOW_W-1:0]             now_us,
  input  wire tsp_pkg::tsp_cmd_t                     cmd,
  output tsp_pkg::tsp_status_t                       status,
  output logic                                       phase_valid,
  output logic [tsp_pkg::TURNS_W-1:0]                phase_turns,
  output logic                                       pressure_valid,
  output logic signed [tsp_pkg::PRESSURE_W-1:0]      pressure,
  output logic                                       spike_hit
);

  import tsp_pkg::*;

  localparam int TW        = TIME_WIDTH;
  localparam int LOG       = $clog2(SINE_TABLE_DEPTH);
  localparam int QD        = SINE_TABLE_DEPTH / 4;
  localparam int IW        = LOG - 1;
  localparam int NW        = (TIME_WIDTH < 48) ? TIME_WIDTH : 48;
  localparam int ROM_SHIFT = 32 - LOG;

  // Configuration.
  logic              enable;
  logic [31:0]       base_pressure;
  logic [STEP_W-1:0] tone_step;
  logic [31:0]       tone_amplitude;
  logic [31:0]       spike_amplitude;
  logic [31:0]       spike_interval;

  // Per-tick working registers.
  logic [TW-1:0]      now_t;
  logic [PHASE_W-1:0] now_p;
  logic [63:0]        prod;
  logic [PHASE_W-1:0] acc;
  logic [30:0]        rom_q;
  logic               quad_neg;
  logic [32:0]        tone_term;
  logic [33:0]        psum;
  logic               hit;
  logic [31:0]        rem;
  logic [TW-1:0]      base_t;

  // Persistent state.
  logic [TW-1:0] next_spike_time;
  logic [TW-1:0] last_publish_time;

  // Combinational helpers.
  logic [31:0]    mul_a;
  logic [31:0]    mul_b;
  logic [31:0]    amp_mag;
  logic [LOG-1:0] k;
  logic [LOG-3:0] k_low;
  logic [IW-1:0]  rom_idx;
  logic [31:0]    tone_mag;
  logic           tone_on;
  logic           spike_on;
  logic [TW-1:0]  per_t;
  logic [TW:0]    arm_sub;
  logic [TW:0]    arm_sum;
  logic           arm_cond;
  logic [TW:0]    chk_diff;
  logic           hit_c;
  logic [TW:0]    adv_sum;
  logic [34:0]    pfull;
  logic [31:0]    psat;
  logic [TW:0]    pub_diff;
  logic           pub;
  logic           div_done;
  logic [31:0]    div_rem;
  logic [30:0]    sine_rom [QD+1];

  // Quarter-wave sine table, filled at elaboration.
  for (genvar g = 0; g <= QD; g++) begin : g_rom
    assign sine_rom[g] = sine_q30(64'(g) << ROM_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable          <= 1'b0;
      base_pressure   <= '0;
      tone_step       <= '0;
      tone_amplitude  <= '0;
      spike_amplitude <= '0;
      spike_interval  <= '0;
    end else if (cfg_write) begin
      case (tsp_reg_t'(cfg_index))
        REG_ENABLE:          enable          <= cfg_data[0];
        REG_BASE_PRESSURE:   base_pressure   <= cfg_data[31:0];
        REG_TONE_STEP:       tone_step       <= cfg_data[STEP_W-1:0];
        REG_TONE_AMPLITUDE:  tone_amplitude  <= cfg_data[31:0];
        REG_SPIKE_AMPLITUDE: spike_amplitude <= cfg_data[31:0];
        REG_SPIKE_PERIOD:    spike_interval  <= cfg_data[31:0];
        default: begin
        end
      endcase
    end
  end

  assign amp_mag  = tone_amplitude[31] ? (~tone_amplitude + 32'd1) : tone_amplitude;
  assign tone_on  = (tone_step != '0) && (tone_amplitude != '0);
  assign spike_on = !spike_amplitude[31] && (spike_amplitude != '0) &&
                    (spike_interval != '0);
  assign per_t    = TW'(spike_interval);

  // Phase is built from 24-bit partial products; only the low 48 bits matter.
  always_comb begin
    case (cmd.mul_sel)
      MUL_LO_LO: begin
        mul_a = {8'd0, tone_step[23:0]};
        mul_b = {8'd0, now_p[23:0]};
      end
      MUL_LO_HI: begin
        mul_a = {8'd0, tone_step[23:0]};
        mul_b = {8'd0, now_p[47:24]};
      end
      MUL_HI_LO: begin
        mul_a = {16'd0, tone_step[39:24]};
        mul_b = {8'd0, now_p[23:0]};
      end
      MUL_TONE: begin
        mul_a = amp_mag;
        mul_b = {1'b0, rom_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Table index from the top of the phase; odd quadrants read the table mirrored.
  assign k       = acc[PHASE_W-1 -: LOG];
  assign k_low   = k[LOG-3:0];
  assign rom_idx = k[LOG-2] ? (IW'(QD) - {1'b0, k_low}) : {1'b0, k_low};

  assign tone_mag = prod[61:30];

  assign arm_sub  = {1'b0, next_spike_time} - {1'b0, per_t};
  assign arm_sum  = {1'b0, now_t} + {1'b0, per_t};
  assign arm_cond = (next_spike_time == '0) || arm_sub[TW] || (now_t < arm_sub[TW-1:0]);

  assign chk_diff = {1'b0, now_t} - {1'b0, next_spike_time};
  assign hit_c    = spike_on && !chk_diff[TW];

  assign adv_sum = {1'b0, base_t} + {1'b0, per_t};

  assign pfull = {psum[33], psum} +
                 (hit ? {{3{spike_amplitude[31]}}, spike_amplitude} : 35'd0);

  always_comb begin
    if ((pfull[34:31] == 4'b0000) || (pfull[34:31] == 4'b1111)) begin
      psat = pfull[31:0];
    end else if (pfull[34]) begin
      psat = 32'h8000_0000;
    end else begin
      psat = 32'h7fff_ffff;
    end
  end

  assign pub_diff = {1'b0, now_t} - {1'b0, last_publish_time};
  assign pub      = pub_diff[TW] || (pub_diff[TW-1:0] >= TW'(PUBLISH_INTERVAL_US));

  tsp_rem #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_rem (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.div_start),
    .dividend(chk_diff[TW-1:0]),
    .divisor (spike_interval),
    .done    (div_done),
    .rem     (div_rem)
  );

  always_comb begin
    status.enable    = enable;
    status.hit       = hit_c;
    status.rem_short = (chk_diff[TW-1:0] < per_t);
    status.div_done  = div_done;
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now_t <= TW'(now_us[NW-1:0]);
      now_p <= PHASE_W'(now_us[NW-1:0]);
    end
    if (cmd.mul_en) begin
      prod <= 64'(mul_a) * 64'(mul_b);
    end
    if (cmd.acc_load) begin
      acc <= prod[PHASE_W-1:0];
    end else if (cmd.acc_add) begin
      acc <= acc + {prod[23:0], 24'd0};
    end
    if (cmd.rom_en) begin
      rom_q    <= sine_rom[rom_idx];
      quad_neg <= k[LOG-1];
    end
    if (cmd.arm_en) begin
      if (!tone_on) begin
        tone_term <= '0;
      end else if (tone_amplitude[31] ^ quad_neg) begin
        tone_term <= 33'd0 - {1'b0, tone_mag};
      end else begin
        tone_term <= {1'b0, tone_mag};
      end
    end
    if (cmd.check_en) begin
      hit  <= hit_c;
      rem  <= chk_diff[31:0];
      psum <= {{2{base_pressure[31]}}, base_pressure} + {tone_term[32], tone_term};
    end else if (div_done) begin
      rem <= div_rem;
    end
    if (cmd.align_en) begin
      base_t <= now_t - TW'(rem);
    end
  end

  // Spike deadline and publish time.
  always_ff @(posedge clk) begin
    if (rst) begin
      next_spike_time   <= '0;
      last_publish_time <= '0;
    end else begin
      if (cmd.arm_en) begin
        if (!spike_on) begin
          next_spike_time <= '0;
        end else if (arm_cond) begin
          next_spike_time <= arm_sum[TW] ? '1 : arm_sum[TW-1:0];
        end
      end else if (cmd.adv_en) begin
        next_spike_time <= adv_sum[TW] ? '1 : adv_sum[TW-1:0];
      end
      if (cmd.finish && pub) begin
        last_publish_time <= now_t;
      end
    end
  end

  // Output word.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      phase_valid    <= (tone_step != '0);
      phase_turns    <= (tone_step != '0) ? acc[47:32] : '0;
      pressure_valid <= pub;
      pressure       <= $signed(psat);
      spike_hit      <= hit;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/tone_and_spike_pressure_generator.sv
// A new tick is taken only once the previous one has left the sequencer; a tick taken while
// disabled leaves it idle. When a spike fires at least a period late, the catch-up goes
// through the bit-serial remainder unit, one bit per cycle.
// Reset (rst, synchronous, active high) clears the configuration, the output valid flag, the
// spike deadline and the publish time to zero and leaves the block idle and disabled.
`default_nettype none

// Tone and spike pressure generator.
//
// Every accepted input word is a time tick carrying the current time in microseconds.
// While the enable register is set, each tick yields exactly one result word: the tone
// phase (tone_step times now_us, modulo one turn of 2^48 units), and a pressure equal to
// the base pressure plus the tone amplitude times the sine of that phase, plus the spike
// amplitude when the spike deadline has passed. The pressure saturates to 32 bits and is
// flagged valid at most once per publish interval (or after time steps backward).
// While disabled, ticks are taken and dropped; only the tick time is latched.
//
// Structure: tsp_ctrl is the sequencer, tsp_datapath holds the configuration, the one
// shared 32x32 multiplier (three partial products for the phase, one for the tone), a
// quarter-wave sine table and the spike and publish timers; tsp_rem computes the
// remainder of the deadline lag by the spike period when a spike is at least one
// period late.
//
// The input side is ready again as soon as the result is in the output register, so the
// next tick is taken while a result word still waits on a stalled output.
// Configuration writes are expected only while the block is idle.
module tone_and_spike_pressure_generator #(
  parameter int SINE_TABLE_DEPTH    = 1024,
  parameter int PUBLISH_INTERVAL_US = 100000,
  parameter int TIME_WIDTH          = 48
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [tsp_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [tsp_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [tsp_pkg::NOW_W-1:0]        now_us,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic                                  phase_valid,
  output logic [tsp_pkg::TURNS_W-1:0]           phase_turns,
  output logic                                  pressure_valid,
  output logic signed [tsp_pkg::PRESSURE_W-1:0] pressure,
  output logic                                  spike_hit
);

  import tsp_pkg::*;

  tsp_cmd_t    cmd;
  tsp_status_t status;

  // The sequencer owns both handshakes; the datapath only follows its commands.
  tsp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status   (status),
    .cmd      (cmd)
  );

  tsp_datapath #(
    .SINE_TABLE_DEPTH   (SINE_TABLE_DEPTH),
    .PUBLISH_INTERVAL_US(PUBLISH_INTERVAL_US),
    .TIME_WIDTH         (TIME_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .now_us        (now_us),
    .cmd           (cmd),
    .status        (status),
    .phase_valid   (phase_valid),
    .phase_turns   (phase_turns),
    .pressure_valid(pressure_valid),
    .pressure      (pressure),
    .spike_hit     (spike_hit)
  );

endmodule

`default_nettype wire

### hw/rtl/tsp_checker.sv
`default_nettype none

`include "tone_and_spike_pressure_generator_macros.svh"

// Port-level checks on the tone and spike pressure generator.
module tsp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        phase_valid,
  input wire logic [15:0] phase_turns,
  input wire logic [31:0] pressure
);

  // A stalled result word keeps its contents.
  `TSP_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                   out_valid && $stable(pressure) && $stable(phase_turns))

  // Without a tone step the phase field reads zero.
  `TSP_ASSERT_NOW(a_phase_zero, out_valid && !phase_valid, phase_turns == 16'd0)

  // A new result only appears after the input side was busy working on it.
  `TSP_ASSERT_NOW(a_rise_after_busy, $rose(out_valid), $past(in_stall))

  // A tick goes through the sequencer before its result is written, so no result appears right after an accept.
  `TSP_ASSERT_NEXT(a_no_instant_result, in_valid && !in_stall, !$rose(out_valid))

endmodule

bind tone_and_spike_pressure_generator tsp_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .phase_valid(phase_valid),
  .phase_turns(phase_turns),
  .pressure   (pressure)
);

`default_nettype wire

### tb/tone_and_spike_pressure_generator_test.sv
`timescale 1ns / 1ps

// One result word of the generator, in port order.
typedef struct packed {
  logic        phase_valid;
  logic [15:0] phase_turns;
  logic        pressure_valid;
  logic [31:0] pressure;
  logic        spike_hit;
} pressure_word_t;

// Predicts the generator from its registers and timers and checks the words it returns.
class pressure_tracker;
  localparam int          SINE_DEPTH      = 1024;
  localparam int          PUBLISH_US      = 100000;
  localparam logic [63:0] TIME_LIMIT      = 64'hFFFF_FFFF_FFFF;
  localparam logic [63:0] Q30_UNIT        = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30_RAD = 64'd1686629713;
  localparam longint      PRESSURE_MAX    = 64'sh7FFF_FFFF;
  localparam longint      PRESSURE_MIN    = -64'sh8000_0000;
  localparam int          PRINT_CAP       = 200;

  bit               enabled;
  bit signed [31:0] base_q8;
  bit [39:0]        tone_step;
  bit signed [31:0] tone_amp_q8;
  bit signed [31:0] spike_amp_q8;
  bit [31:0]        spike_interval;
  bit [47:0]        next_spike;
  bit [47:0]        last_publish;
  pressure_word_t   due_words[$];
  int               mismatch_count;

  task report(string msg);
    if (mismatch_count < PRINT_CAP) begin
      $display("MISMATCH at %0t ns: %s", $time, msg);
    end
    mismatch_count++;
  endtask

  function void write_reg(bit [2:0] index, bit [39:0] value);
    case (index)
      tsp_pkg::REG_ENABLE:          enabled        = value[0];
      tsp_pkg::REG_BASE_PRESSURE:   base_q8        = value[31:0];
      tsp_pkg::REG_TONE_STEP:       tone_step      = value;
      tsp_pkg::REG_TONE_AMPLITUDE:  tone_amp_q8    = value[31:0];
      tsp_pkg::REG_SPIKE_AMPLITUDE: spike_amp_q8   = value[31:0];
      tsp_pkg::REG_SPIKE_PERIOD:    spike_interval = value[31:0];
      default: ;
    endcase
  endfunction

  function bit [63:0] time_sum(bit [63:0] a, bit [63:0] b);
    if (b > TIME_LIMIT - a) return TIME_LIMIT;
    return a + b;
  endfunction

  // Sine of table entry k in Q30, built from a quarter wave and a Taylor series.
  function longint sine_of_entry(bit [63:0] k);
    bit [63:0] turn;
    bit [63:0] frac;
    bit [63:0] theta;
    bit [63:0] theta_sq;
    bit [63:0] term;
    bit [63:0] divisor;
    longint    acc;
    int        n;
    turn = (k << 32) / 64'(SINE_DEPTH);
    frac = turn & (Q30_UNIT - 64'd1);
    if (turn[30]) frac = Q30_UNIT - frac;
    theta    = (frac * HALF_PI_Q30_RAD) >> 30;
    theta_sq = (theta * theta) >> 30;
    term     = theta;
    acc      = longint'(theta);
    for (n = 1; n <= 6; n++) begin
      divisor = 64'((2 * n) * (2 * n + 1));
      term = ((term * theta_sq) >> 30) / divisor;
      if (n % 2 == 1) acc -= longint'(term);
      else acc += longint'(term);
    end
    if (acc < 0) acc = 0;
    if (acc > longint'(Q30_UNIT)) acc = longint'(Q30_UNIT);
    return turn[31] ? -acc : acc;
  endfunction

  // An accepted tick: update the timers and queue the word it must produce.
  function void take_tick(bit [47:0] now);
    bit [47:0]      step_wide;
    bit [47:0]      phase;
    bit [63:0]      k;
    bit [63:0]      mag_amp;
    bit [63:0]      mag_sin;
    bit [63:0]      tone_mag;
    bit [63:0]      period;
    bit [63:0]      deadline;
    bit [63:0]      now_wide;
    longint         amp;
    longint         sin_q30;
    longint         spike;
    longint         level;
    bit             hit;
    bit             publish;
    pressure_word_t word;
    if (!enabled) return;
    step_wide = 48'(tone_step);
    now_wide  = 64'(now);
    phase     = step_wide * now;
    level     = longint'(base_q8);
    amp       = longint'(tone_amp_q8);
    spike     = longint'(spike_amp_q8);
    hit       = 1'b0;

    if (tone_step != 0 && amp != 0) begin
      k        = ({16'd0, phase} * 64'(SINE_DEPTH)) >> 48;
      sin_q30  = sine_of_entry(k);
      mag_amp  = (amp < 0) ? -amp : amp;
      mag_sin  = (sin_q30 < 0) ? -sin_q30 : sin_q30;
      tone_mag = (mag_amp * mag_sin) >> 30;
      level += ((amp < 0) != (sin_q30 < 0)) ? -longint'(tone_mag) : longint'(tone_mag);
    end

    if (spike > 0 && spike_interval != 0) begin
      period   = 64'(spike_interval);
      deadline = 64'(next_spike);
      if (deadline == 0 || deadline < period || now_wide < deadline - period) begin
        deadline = time_sum(now_wide, period);
      end
      if (now_wide >= deadline) begin
        level += spike;
        hit = 1'b1;
        deadline = time_sum(now_wide - (now_wide - deadline) % period, period);
      end
      next_spike = deadline[47:0];
    end else begin
      next_spike = '0;
    end

    if (level > PRESSURE_MAX) level = PRESSURE_MAX;
    if (level < PRESSURE_MIN) level = PRESSURE_MIN;

    publish = (now < last_publish) || (now - last_publish >= 48'(PUBLISH_US));
    if (publish) last_publish = now;

    word.phase_valid    = (tone_step != 0);
    word.phase_turns    = (tone_step != 0) ? phase[47:32] : 16'd0;
    word.pressure_valid = publish;
    word.pressure       = level[31:0];
    word.spike_hit      = hit;
    due_words.push_back(word);
  endfunction

  task compare_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report($sformatf("%s is %h, %h expected", name, got, want));
  endtask

  task check_word(pressure_word_t got);
    pressure_word_t want;
    if (due_words.size() == 0) begin
      report($sformatf("word with pressure %h arrived with nothing expected", got.pressure));
      return;
    end
    want = due_words.pop_front();
    compare_field("phase_valid", 32'(got.phase_valid), 32'(want.phase_valid));
    compare_field("phase_turns", 32'(got.phase_turns), 32'(want.phase_turns));
    compare_field("pressure_valid", 32'(got.pressure_valid), 32'(want.pressure_valid));
    compare_field("pressure", got.pressure, want.pressure);
    compare_field("spike_hit", 32'(got.spike_hit), 32'(want.spike_hit));
  endtask
endclass

// Testbench for the tone and spike pressure generator.
//
// Ticks are driven on the falling edge and every accepted tick is handed to the tracker,
// which predicts the word it must cause. Result words are sampled on the rising edge and
// compared field by field, in order, with the oldest prediction.
module tone_and_spike_pressure_generator_test;
  import tsp_pkg::*;

  localparam int     HALF_PERIOD_NS   = 6;
  localparam int     RESET_CYCLES     = 5;
  // Generics of the block under test; the tracker is built for the same values.
  localparam int     TABLE_DEPTH      = 1024;
  localparam int     PUBLISH_INTERVAL = 100000;
  localparam int     TIME_BITS        = 48;
  // Settle time after a drain; it covers a tick that catches up by many periods.
  localparam int     SETTLE_CYCLES    = 80;
  localparam int     HOLD_CYCLES      = 300;
  localparam int     DRAIN_LIMIT      = 4000;
  localparam int     SETTINGS_RUN     = 11;
  localparam int     TICKS_PER_RUN    = 46;
  localparam longint RUN_LIMIT_NS     = 36_000_000;

  // Indexes past the last register; writes to them must have no effect.
  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_HI = 3'd7;

  localparam logic [NOW_W-1:0] TIME_TOP = '1;

  logic                         clk = 1'b0;
  logic                         rst;
  logic                         cfg_write;
  logic [CFG_INDEX_W-1:0]       cfg_index;
  logic [CFG_DATA_W-1:0]        cfg_data;
  logic                         in_valid;
  logic                         in_stall;
  logic [NOW_W-1:0]             now_us;
  logic                         out_valid;
  logic                         out_stall;
  logic                         phase_valid;
  logic [TURNS_W-1:0]           phase_turns;
  logic                         pressure_valid;
  logic signed [PRESSURE_W-1:0] pressure;
  logic                         spike_hit;

  pressure_tracker tracker = new();

  // Chances, in percent, that the sender idles or the receiver stalls in a given cycle.
  int send_idle_pct;
  int recv_stall_pct;
  // Set by the stimulus to ask for one long stall of the output.
  bit hold_wanted;
  bit hold_active;

  tone_and_spike_pressure_generator #(
    .SINE_TABLE_DEPTH   (TABLE_DEPTH),
    .PUBLISH_INTERVAL_US(PUBLISH_INTERVAL),
    .TIME_WIDTH         (TIME_BITS)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .now_us        (now_us),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .phase_valid   (phase_valid),
    .phase_turns   (phase_turns),
    .pressure_valid(pressure_valid),
    .pressure      (pressure),
    .spike_hit     (spike_hit)
  );

  always begin
    clk = 1'b0;
    #HALF_PERIOD_NS;
    clk = 1'b1;
    #HALF_PERIOD_NS;
  end

  // Hard stop in case the block hangs or loses its handshake.
  initial begin
    #(RUN_LIMIT_NS);
    $display("Test completed with failures");
    $finish;
  end

  // The long output stall is timed here, independent of the stimulus, so the sender
  // keeps offering ticks until the block's input stalls.
  always begin
    @(negedge clk);
    if (hold_wanted) begin
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(negedge clk);
      hold_active <= 1'b0;
      hold_wanted = 1'b0;
    end
  end

  // Receiver: random stalls, set on the falling edge.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= hold_active || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // A result word is taken at a rising edge where out_valid is high and out_stall low.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      tracker.check_word({phase_valid, phase_turns, pressure_valid, pressure, spike_hit});
    end
  end

  // One register write; the enable drops again on the next falling edge.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    tracker.write_reg(index, value);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] en, input logic [CFG_DATA_W-1:0] base,
                           input logic [CFG_DATA_W-1:0] step, input logic [CFG_DATA_W-1:0] tone,
                           input logic [CFG_DATA_W-1:0] spike, input logic [CFG_DATA_W-1:0] per);
    write_reg(REG_ENABLE, en);
    write_reg(REG_BASE_PRESSURE, base);
    write_reg(REG_TONE_STEP, step);
    write_reg(REG_TONE_AMPLITUDE, tone);
    write_reg(REG_SPIKE_AMPLITUDE, spike);
    write_reg(REG_SPIKE_PERIOD, per);
  endtask

  // Offers one tick word and returns at the rising edge that takes it. The idle choice is
  // made before valid rises, so valid never follows the stall.
  task automatic send_tick(input logic [NOW_W-1:0] stamp);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    now_us   <= stamp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.take_tick(stamp);
  endtask

  task automatic stop_ticks;
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Waits until every predicted word has come back, then lets the block settle so that
  // it is idle before the next register write. Words that never come are failures.
  task automatic drain;
    int waited;
    waited = 0;
    while (tracker.due_words.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (tracker.due_words.size() != 0) begin
      tracker.report($sformatf("%0d expected words never arrived", tracker.due_words.size()));
      tracker.due_words.delete();
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    int                    idle_phase;
    int                    setting;
    int                    tick;
    logic [NOW_W-1:0]      stamp;
    logic [31:0]           period;
    logic [CFG_DATA_W-1:0] en_word;
    logic [CFG_DATA_W-1:0] base_word;
    logic [CFG_DATA_W-1:0] step_word;
    logic [CFG_DATA_W-1:0] tone_word;
    logic [CFG_DATA_W-1:0] spike_word;
    logic [CFG_DATA_W-1:0] period_word;

    rst            = 1'b1;
    cfg_write      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    in_valid       = 1'b0;
    now_us         = '0;
    send_idle_pct  = 26;
    recv_stall_pct = 52;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // ---- Directed part ----

    // Straight after reset the block is disabled: the tick is taken and nothing comes out.
    send_tick(48'd12345);
    stop_ticks();
    drain();

    // Every value at its positive extreme with a period of one microsecond: the pressure
    // saturates high, spikes fire on every later tick but the step back in time, which
    // re-arms the deadline, and the last tick sits at the top of the time range.
    configure(40'd1, 40'h7FFF_FFFF, 40'hFF_FFFF_FFFF, 40'h7FFF_FFFF, 40'h7FFF_FFFF, 40'd1);
    send_tick(48'd0);
    send_tick(48'd5);
    send_tick(48'd3);
    send_tick(48'd200000);
    send_tick(TIME_TOP);
    stop_ticks();
    drain();

    // Negative extremes, spikes switched off by a zero height, the longest period, and an
    // enable write with junk above bit 0. Writes past the last register must be ignored.
    configure(40'hFF_FFFF_FFFF, 40'h8000_0000, 40'd1, 40'h8000_0000, 40'd0, 40'hFFFF_FFFF);
    write_reg(REG_UNMAPPED_LO, 40'hFF_FFFF_FFFF);
    write_reg(REG_UNMAPPED_HI, 40'h00_0000_0000);
    send_tick(48'd0);
    send_tick(48'd1);
    send_tick(48'd100000);
    send_tick(48'd99999);
    send_tick(TIME_TOP);
    stop_ticks();
    drain();

    // No tone step, so the phase is not valid; a negative spike height clears the deadline.
    configure(40'd1, 40'd0, 40'd0, 40'h1234, 40'hFFFF_FF00, 40'd1000);
    send_tick(48'd0);
    send_tick(48'd50);
    stop_ticks();
    drain();

    // Spike timing: a hit exactly on the deadline, a tick just short of the next deadline, a
    // catch-up over many periods, a repeated time with no hit, then hits near the top where
    // the deadline sum saturates.
    configure(40'd1, 40'd100, 40'h40_0000_0000, 40'd0, 40'd5000, 40'd1000);
    send_tick(48'd0);
    send_tick(48'd500);
    send_tick(48'd1000);
    send_tick(48'd1999);
    send_tick(48'd10500);
    send_tick(48'd10500);
    send_tick(TIME_TOP - 48'd1500);
    send_tick(TIME_TOP);
    stop_ticks();
    drain();

    // Enable written as zero with other bits set: the tick is dropped.
    configure(40'hFE, 40'd0, 40'd0, 40'd0, 40'd0, 40'd0);
    send_tick(48'd777);
    stop_ticks();
    drain();

    // ---- Random part ----
    // Three idle patterns in turn: sender idles less than the receiver stalls, then the
    // reverse, then neither side idles at all.
    for (idle_phase = 0; idle_phase < 3; idle_phase++) begin
      case (idle_phase)
        0: begin
          send_idle_pct  = 26;
          recv_stall_pct = 52;
        end
        1: begin
          send_idle_pct  = 52;
          recv_stall_pct = 26;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase

      for (setting = 0; setting < SETTINGS_RUN; setting++) begin
        // Bits above each register's width are filled with junk; the block must drop them.
        en_word    = CFG_DATA_W'({$urandom(), $urandom()});
        en_word[0] = ($urandom_range(11) != 0);

        base_word = CFG_DATA_W'({$urandom(), $urandom()});
        case ($urandom_range(5))
          0: base_word[31:0] = 32'h7FFF_FFFF;
          1: base_word[31:0] = 32'h8000_0000;
          2: ;
          default: base_word[31:0] = 32'($urandom_range(67108864, 0)) - 32'd33554432;
        endcase

        case ($urandom_range(5))
          0: step_word = '0;
          1: step_word = '1;
          2: step_word = CFG_DATA_W'({$urandom(), $urandom()});
          default: step_word = 40'($urandom_range(4194304, 1));
        endcase

        tone_word = CFG_DATA_W'({$urandom(), $urandom()});
        case ($urandom_range(6))
          0: tone_word[31:0] = 32'd0;
          1: tone_word[31:0] = 32'h8000_0000;
          2: tone_word[31:0] = 32'h7FFF_FFFF;
          3: ;
          default: tone_word[31:0] = 32'($urandom_range(2097152, 0)) - 32'd1048576;
        endcase

        spike_word = CFG_DATA_W'({$urandom(), $urandom()});
        case ($urandom_range(6))
          0: spike_word[31:0] = 32'd0;
          1: spike_word[31:0] = $urandom() | 32'h8000_0000;
          2: spike_word[31:0] = 32'h7FFF_FFFF;
          default: spike_word[31:0] = $urandom_range(16777216, 1);
        endcase

        period_word = CFG_DATA_W'({$urandom(), $urandom()});
        case ($urandom_range(9))
          0: period_word[31:0] = 32'd0;
          1: period_word[31:0] = 32'hFFFF_FFFF;
          2: period_word[31:0] = 32'd1;
          3: ;
          default: period_word[31:0] = $urandom_range(60000, 1);
        endcase
        period = period_word[31:0];

        configure(en_word, base_word, step_word, tone_word, spike_word, period_word);
        if ($urandom_range(3) == 0) begin
          write_reg($urandom_range(1) ? REG_UNMAPPED_HI : REG_UNMAPPED_LO,
                    CFG_DATA_W'({$urandom(), $urandom()}));
        end

        // At most once per idle pattern the output stalls for a long time while ticks come.
        if (setting == 4 && en_word[0]) hold_wanted = 1'b1;

        case ($urandom_range(9))
          0: stamp = NOW_W'({$urandom(), $urandom()});
          1: stamp = TIME_TOP - 48'($urandom_range(2000000, 0));
          default: stamp = 48'($urandom_range(5000000, 0));
        endcase

        // Time mostly moves forward by up to a quarter of a publish interval, sometimes by
        // whole spike periods, and now and then jumps back or anywhere.
        for (tick = 0; tick < TICKS_PER_RUN; tick++) begin
          case ($urandom_range(19))
            0: stamp = stamp - 48'($urandom_range(300000, 1));
            1: stamp = stamp + 48'($urandom());
            2: stamp = NOW_W'({$urandom(), $urandom()});
            3, 4: stamp = stamp + 48'(period) * 48'($urandom_range(40, 1))
                          + 48'($urandom_range(3, 0));
            default: stamp = stamp + 48'($urandom_range(25000, 0));
          endcase
          send_tick(stamp);
        end
        stop_ticks();
        drain();
      end
    end

    if (tracker.mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/tsp_pkg.sv
hw/rtl/tsp_rem.sv
hw/rtl/tsp_ctrl.sv
hw/rtl/tsp_datapath.sv
hw/rtl/tone_and_spike_pressure_generator.sv
hw/rtl/tsp_checker.sv
tb/tone_and_spike_pressure_generator_test.sv
